>>> src/spd_pkg.sv
// Shared constants, register codes and types for the snore periodicity detector.
`default_nettype none

package spd_pkg;

  // Default sizes handed to the top level parameters
  localparam int WINDOW_MAX_DEF    = 64;
  localparam int HISTORY_DEPTH_DEF = 3;
  localparam int FRAME_MAX_DEF     = 1023;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 16;
  localparam int WSIZE_W    = 7;
  localparam int FLEN_W     = 10;
  localparam int COUNT_W    = 7;
  localparam int RUN_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [RUN_W-1:0] RUN_MAX = {RUN_W{1'b1}};

  // Register reset values
  localparam logic [LEVEL_W-1:0] LEVEL_THRESHOLD_RST = 16'd0;
  localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RST     = 7'd16;
  localparam logic [FLEN_W-1:0]  FRAME_LENGTH_RST    = 10'd200;
  localparam logic [WSIZE_W-1:0] ON_COUNT_RST        = 7'd8;
  localparam logic [WSIZE_W-1:0] OFF_COUNT_RST       = 7'd2;
  localparam logic [RUN_W-1:0]   QUIET_LIMIT_RST     = 16'd100;
  localparam logic [RUN_W-1:0]   TOLERANCE_RST       = 16'd5;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_WINDOW_SIZE     = 3'd1,
    REG_FRAME_LENGTH    = 3'd2,
    REG_ON_COUNT        = 3'd3,
    REG_OFF_COUNT       = 3'd4,
    REG_QUIET_LIMIT     = 3'd5,
    REG_TOLERANCE       = 3'd6
  } cfg_idx_e;

  // Configuration register set
  typedef struct packed {
    logic signed [LEVEL_W-1:0] level_threshold;
    logic [WSIZE_W-1:0]        window_size;
    logic [FLEN_W-1:0]         frame_length;
    logic [WSIZE_W-1:0]        on_count;
    logic [WSIZE_W-1:0]        off_count;
    logic [RUN_W-1:0]          quiet_limit;
    logic [RUN_W-1:0]          tolerance;
  } cfg_t;

  // Burst tracker state after the current request
  typedef struct packed {
    logic snore;
    logic burst;
  } status_t;

endpackage

`default_nettype wire

>>> src/spd_window.sv
// Frame position tracking, loud-bit shift line and windowed loud count.
`default_nettype none

module spd_window import spd_pkg::*; #(
  parameter  int WINDOW_MAX = WINDOW_MAX_DEF,
  parameter  int FRAME_MAX  = FRAME_MAX_DEF,
  localparam int CNT_W      = $clog2(WINDOW_MAX + 1)
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       step_i,
  input  wire logic signed [SAMPLE_W-1:0] sample_i,
  input  wire logic                       frame_start_i,
  input  wire cfg_t                       cfg_i,
  output logic                            win_valid_o,
  output logic [CNT_W-1:0]                win_count_o
);

  localparam int POS_W = $clog2(FRAME_MAX + 1);
  localparam int WS_W  = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;
  localparam int CMP_W = ((POS_W > FLEN_W) ? POS_W : FLEN_W) + 2;

  logic [WINDOW_MAX-1:0] loud_q, loud_d, loud_base, win_bits;
  logic [POS_W-1:0]      pos_q, pos_d, pos_cur;
  logic [WS_W-1:0]       wsz_raw, wsz;
  logic                  loud;
  logic [CNT_W-1:0]      count;

  // Classify the sample and clamp the window length
  assign loud    = (sample_i >= cfg_i.level_threshold);
  assign wsz_raw = WS_W'(cfg_i.window_size);

  always_comb begin
    if (wsz_raw == '0) begin
      wsz = WS_W'(1);
    end else if (wsz_raw > WS_W'(WINDOW_MAX)) begin
      wsz = WS_W'(WINDOW_MAX);
    end else begin
      wsz = wsz_raw;
    end
  end

  // Restart the frame on a start flag, newest loud bit enters at bit 0
  assign pos_cur   = frame_start_i ? '0 : pos_q;
  assign loud_base = frame_start_i ? '0 : loud_q;
  assign loud_d    = {loud_base[WINDOW_MAX-2:0], loud};
  assign pos_d     = (pos_cur < POS_W'(FRAME_MAX)) ? pos_cur + POS_W'(1) : pos_cur;

  // Keep only the bits that fall inside the window
  for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_mask
    assign win_bits[i] = loud_d[i] & (WS_W'(i) < wsz);
  end

  // Count loud samples in the window
  always_comb begin
    count = '0;
    for (int i = 0; i < WINDOW_MAX; i++) begin
      count = count + CNT_W'(win_bits[i]);
    end
  end

  // A window ends here when it fits the frame and stops before its last sample
  assign win_valid_o = (CMP_W'(pos_cur) + CMP_W'(1) >= CMP_W'(wsz)) &&
                       (CMP_W'(pos_cur) + CMP_W'(2) <= CMP_W'(cfg_i.frame_length));
  assign win_count_o = count;

  // Advance position and shift line on each request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      loud_q <= '0;
      pos_q  <= '0;
    end else if (step_i) begin
      loud_q <= loud_d;
      pos_q  <= pos_d;
    end
  end

endmodule

`default_nettype wire

>>> src/spd_burst.sv
// Hysteresis burst tracker, burst length history and snore judgment.
`default_nettype none

module spd_burst import spd_pkg::*; #(
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int CNT_W         = 7
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             win_valid_i,
  input  wire logic [CNT_W-1:0] win_count_i,
  input  wire cfg_t             cfg_i,
  output status_t               status_o
);

  localparam int CMP_W = (CNT_W > WSIZE_W) ? CNT_W : WSIZE_W;

  logic                     burst_q, burst_d;
  logic                     snore_q, snore_d;
  logic [RUN_W-1:0]         run_q, run_d, run_inc;
  logic [RUN_W-1:0]         hist_q    [HISTORY_DEPTH];
  logic [RUN_W-1:0]         hist_d    [HISTORY_DEPTH];
  logic [RUN_W-1:0]         hist_push [HISTORY_DEPTH];
  logic [HISTORY_DEPTH-1:0] hval_q, hval_d, hval_push;
  logic [HISTORY_DEPTH-1:0] close_ok;
  logic [CMP_W-1:0]         cnt, on_cnt, off_cnt;
  logic                     at_on, at_off, quiet_hit, quiet_first, match;

  // Compare the window count against both thresholds
  assign cnt     = CMP_W'(win_count_i);
  assign on_cnt  = CMP_W'(cfg_i.on_count);
  assign off_cnt = CMP_W'(cfg_i.off_count);
  assign at_on   = (cnt >= on_cnt);
  assign at_off  = (cnt <= off_cnt);

  // Saturating run count and quiet checks
  assign run_inc     = (run_q == RUN_MAX) ? run_q : run_q + RUN_W'(1);
  assign quiet_hit   = (run_inc >= cfg_i.quiet_limit);
  assign quiet_first = (cfg_i.quiet_limit <= RUN_W'(1));

  // History as it would look after pushing the closing run
  assign hval_push = {hval_q[HISTORY_DEPTH-2:0], 1'b1};
  always_comb begin
    hist_push[0] = run_q;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      hist_push[i] = hist_q[i-1];
    end
  end

  // Newest length against each older one
  always_comb begin
    close_ok[0] = 1'b1;
    for (int i = 1; i < HISTORY_DEPTH; i++) begin
      if (hist_push[0] > hist_push[i]) begin
        close_ok[i] = (hist_push[0] - hist_push[i]) <= cfg_i.tolerance;
      end else begin
        close_ok[i] = (hist_push[i] - hist_push[0]) <= cfg_i.tolerance;
      end
    end
  end
  assign match = (&hval_push) && (&close_ok);

  // Hysteresis step, with the switched window handled again in the new state
  always_comb begin
    burst_d = burst_q;
    snore_d = snore_q;
    run_d   = run_q;
    hval_d  = hval_q;
    hist_d  = hist_q;
    if (win_valid_i) begin
      if (burst_q) begin
        if (at_off) begin
          burst_d = 1'b0;
          hist_d  = hist_push;
          hval_d  = hval_push;
          snore_d = snore_q | match;
          run_d   = '0;
          if (!at_on) begin
            run_d = RUN_W'(1);
            if (quiet_first) begin
              hval_d  = '0;
              snore_d = 1'b0;
            end
          end
        end else begin
          run_d = run_inc;
        end
      end else begin
        if (at_on) begin
          burst_d = 1'b1;
          run_d   = at_off ? '0 : RUN_W'(1);
        end else begin
          run_d = run_inc;
          if (quiet_hit) begin
            hval_d  = '0;
            snore_d = 1'b0;
          end
        end
      end
    end
  end

  assign status_o.snore = snore_d;
  assign status_o.burst = burst_d;

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      burst_q <= 1'b0;
      snore_q <= 1'b0;
      run_q   <= '0;
      hval_q  <= '0;
    end else if (step_i) begin
      burst_q <= burst_d;
      snore_q <= snore_d;
      run_q   <= run_d;
      hval_q  <= hval_d;
    end
  end

  // History lengths are only read behind their valid bits
  always_ff @(posedge clk_i) begin
    if (step_i) begin
      hist_q <= hist_d;
    end
  end

endmodule

`default_nettype wire

>>> src/snore_periodicity_detector_core.sv
// Top level of the snore periodicity detector: stream ports, registers, pipeline.
`default_nettype none

// Takes one sound-level sample per clock on the slave stream while the output
// is not stalled (sample in tdata, frame start flag in tuser) and returns one
// result per sample on the master stream: the accepted sample waits in the
// input register while the window count and burst update are worked out, and
// lands in the result register once that register is free or being drained.
// The loud count over the window is a single population count of the loud-bit
// shift line, so window changes take effect at once. Configuration registers
// are written through the cfg port and should only change while no sample is
// in flight.

module snore_periodicity_detector_core import spd_pkg::*; #(
  parameter int WINDOW_MAX    = WINDOW_MAX_DEF,
  parameter int HISTORY_DEPTH = HISTORY_DEPTH_DEF,
  parameter int FRAME_MAX     = FRAME_MAX_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Sample stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [15:0]           s_axis_tdata,  // [15:0] sample
  input  wire logic                  s_axis_tuser,  // [0] frame_start
  // Result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [15:0]                m_axis_tdata,  // [0] snore_detected, [7:1] loud_count,
                                                    // [8] in_burst, [15:9] zero
  output logic                       m_axis_tuser   // [0] window_valid
);

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  cfg_t                       cfg_q;
  logic                       in_valid_q;
  logic signed [SAMPLE_W-1:0] sample_q;
  logic                       fstart_q;
  logic                       accept, step;
  logic                       win_valid;
  logic [CNT_W-1:0]           win_count;
  status_t                    status;
  logic                       out_valid_q;
  logic                       out_snore_q, out_wvalid_q, out_burst_q;
  logic [COUNT_W-1:0]         out_count_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.level_threshold <= LEVEL_THRESHOLD_RST;
      cfg_q.window_size     <= WINDOW_SIZE_RST;
      cfg_q.frame_length    <= FRAME_LENGTH_RST;
      cfg_q.on_count        <= ON_COUNT_RST;
      cfg_q.off_count       <= OFF_COUNT_RST;
      cfg_q.quiet_limit     <= QUIET_LIMIT_RST;
      cfg_q.tolerance       <= TOLERANCE_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= LEVEL_W'(cfg_data_i);
        REG_WINDOW_SIZE:     cfg_q.window_size     <= WSIZE_W'(cfg_data_i);
        REG_FRAME_LENGTH:    cfg_q.frame_length    <= FLEN_W'(cfg_data_i);
        REG_ON_COUNT:        cfg_q.on_count        <= WSIZE_W'(cfg_data_i);
        REG_OFF_COUNT:       cfg_q.off_count       <= WSIZE_W'(cfg_data_i);
        REG_QUIET_LIMIT:     cfg_q.quiet_limit     <= RUN_W'(cfg_data_i);
        REG_TOLERANCE:       cfg_q.tolerance       <= RUN_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Handshake: process when the result register is free or being drained
  assign step          = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || step;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (step) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sample_q <= $signed(s_axis_tdata[SAMPLE_W-1:0]);
      fstart_q <= s_axis_tuser;
    end
  end

  spd_window #(
    .WINDOW_MAX (WINDOW_MAX),
    .FRAME_MAX  (FRAME_MAX)
  ) u_window (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .sample_i      (sample_q),
    .frame_start_i (fstart_q),
    .cfg_i         (cfg_q),
    .win_valid_o   (win_valid),
    .win_count_o   (win_count)
  );

  spd_burst #(
    .HISTORY_DEPTH (HISTORY_DEPTH),
    .CNT_W         (CNT_W)
  ) u_burst (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .win_valid_i (win_valid),
    .win_count_i (win_count),
    .cfg_i       (cfg_q),
    .status_o    (status)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (step) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_snore_q  <= status.snore;
      out_wvalid_q <= win_valid;
      out_count_q  <= win_valid ? COUNT_W'(win_count) : '0;
      out_burst_q  <= status.burst;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'd0, out_burst_q, out_count_q, out_snore_q};
  assign m_axis_tuser  = out_wvalid_q;

endmodule

`default_nettype wire
